// File: sv/mphf_pkg.sv
// shared types, codes and constants of the magnetometer poll and health sequencer
package mphf_pkg;

    localparam int TIME_BITS_DEFAULT = 32;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_ID   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAILURE_LIMIT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESET_TIMEOUT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_READY_MASK    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_OVERFLOW_MASK = 3'd4;

    localparam logic [7:0]  EXPECTED_ID_RST   = 8'd72;
    localparam logic [7:0]  FAILURE_LIMIT_RST = 8'd10;
    localparam logic [15:0] RESET_TIMEOUT_RST = 16'd1000;
    localparam logic [7:0]  READY_MASK_RST    = 8'd1;
    localparam logic [7:0]  OVERFLOW_MASK_RST = 8'd8;

    localparam logic [2:0] ACT_NONE       = 3'd0;
    localparam logic [2:0] ACT_SOFT_RESET = 3'd1;
    localparam logic [2:0] ACT_REQ_ID     = 3'd2;
    localparam logic [2:0] ACT_CONT_MODE  = 3'd3;
    localparam logic [2:0] ACT_REQ_DATA   = 3'd4;

    localparam logic [9:0] DELAY_NONE    = 10'd0;
    localparam logic [9:0] DELAY_RESTART = 10'd1000;
    localparam logic [9:0] DELAY_RETRY   = 10'd100;
    localparam logic [9:0] DELAY_POLL    = 10'd20;

    localparam logic [7:0] SCORE_UP  = 8'd2;
    localparam logic [7:0] SCORE_MAX = 8'd255;

    typedef enum logic [1:0] {
        PH_RESET   = 2'd0,
        PH_REQ_ID  = 2'd1,
        PH_WAIT_ID = 2'd2,
        PH_POLL    = 2'd3
    } phase_t;

    typedef struct packed {
        logic        command;
        logic [31:0] now_ms;
        logic        transfer_ok;
        logic [7:0]  id_byte;
        logic [7:0]  status_one;
        logic [7:0]  status_two;
        logic [7:0]  x_low;
        logic [7:0]  x_high;
        logic [7:0]  y_low;
        logic [7:0]  y_high;
        logic [7:0]  z_low;
        logic [7:0]  z_high;
    } item_t;

    typedef struct packed {
        logic [2:0]         bus_action;
        logic [9:0]         next_delay_ms;
        logic               sample_valid;
        logic signed [15:0] mag_x;
        logic signed [15:0] mag_y;
        logic signed [15:0] mag_z;
        logic               overflow_seen;
        logic               bad_read;
    } result_t;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  wdata;
        logic                   wr_en;
    } cfg_wr_t;

endpackage

// File: sv/mphf_in_reg.sv
// input register stage holding one accepted step
module mphf_in_reg (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  mphf_pkg::item_t s_item,
    input  logic            take,
    output logic            q_valid,
    output mphf_pkg::item_t q_item
);
    import mphf_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_ready    = !valid_reg || take;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign q_valid = valid_reg;
    assign q_item  = item_reg;
endmodule

// File: sv/mphf_core.sv
// sequencer state, configuration registers and single-pass step logic
module mphf_core #(
    parameter int TIME_BITS = mphf_pkg::TIME_BITS_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  mphf_pkg::cfg_wr_t cfg,
    input  logic              fire,
    input  mphf_pkg::item_t   item,
    output mphf_pkg::result_t res
);
    import mphf_pkg::*;

    localparam int EXT_BITS = (TIME_BITS > 32) ? TIME_BITS : 32;

    phase_t               phase_reg, phase_next;
    logic [7:0]           score_reg, score_next;
    logic [TIME_BITS-1:0] rst_time_reg, rst_time_next;

    logic [7:0]  expected_id_reg;
    logic [7:0]  failure_limit_reg;
    logic [15:0] timeout_reg;
    logic [7:0]  ready_mask_reg;
    logic [7:0]  overflow_mask_reg;

    logic [EXT_BITS-1:0]  now_ext;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] elapsed;
    logic                 timed_out;
    logic                 id_match;
    logic                 ovf_hit;
    logic                 good;
    logic [8:0]           score_sum;
    logic [7:0]           score_raised;
    logic [7:0]           score_lowered;
    logic                 over_limit;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_id_reg   <= EXPECTED_ID_RST;
            failure_limit_reg <= FAILURE_LIMIT_RST;
            timeout_reg       <= RESET_TIMEOUT_RST;
            ready_mask_reg    <= READY_MASK_RST;
            overflow_mask_reg <= OVERFLOW_MASK_RST;
        end else if (cfg.wr_en) begin
            unique case (cfg.index)
                CFG_EXPECTED_ID:   expected_id_reg   <= cfg.wdata[7:0];
                CFG_FAILURE_LIMIT: failure_limit_reg <= cfg.wdata[7:0];
                CFG_RESET_TIMEOUT: timeout_reg       <= cfg.wdata;
                CFG_READY_MASK:    ready_mask_reg    <= cfg.wdata[7:0];
                CFG_OVERFLOW_MASK: overflow_mask_reg <= cfg.wdata[7:0];
                default: ;
            endcase
        end
    end

    assign now_ext   = EXT_BITS'(item.now_ms);
    assign now_t     = now_ext[TIME_BITS-1:0];
    assign elapsed   = now_t - rst_time_reg;
    assign timed_out = elapsed > TIME_BITS'(timeout_reg);
    assign id_match  = item.id_byte == expected_id_reg;

    assign ovf_hit = item.transfer_ok && ((item.status_two & overflow_mask_reg) != 8'd0);
    assign good    = item.transfer_ok && !ovf_hit
                     && ((item.status_one & ready_mask_reg) != 8'd0);

    assign score_sum     = {1'b0, score_reg} + {1'b0, SCORE_UP};
    assign score_raised  = score_sum[8] ? SCORE_MAX : score_sum[7:0];
    assign score_lowered = (score_reg != 8'd0) ? score_reg - 8'd1 : 8'd0;
    assign over_limit    = score_raised > failure_limit_reg;

    // next state
    always_comb begin
        phase_next    = phase_reg;
        score_next    = score_reg;
        rst_time_next = rst_time_reg;
        if (item.command) begin
            phase_next = PH_RESET;
        end else begin
            unique case (phase_reg)
                PH_RESET: begin
                    phase_next    = PH_REQ_ID;
                    score_next    = 8'd0;
                    rst_time_next = now_t;
                end
                PH_REQ_ID: begin
                    phase_next = PH_WAIT_ID;
                end
                PH_WAIT_ID: begin
                    if (id_match) begin
                        phase_next = PH_POLL;
                    end else if (timed_out) begin
                        phase_next = PH_RESET;
                    end
                end
                PH_POLL: begin
                    if (good) begin
                        score_next = score_lowered;
                    end else begin
                        score_next = score_raised;
                        if (over_limit) begin
                            phase_next = PH_RESET;
                        end
                    end
                end
                default: phase_next = PH_RESET;
            endcase
        end
    end

    // result
    always_comb begin
        res               = '0;
        res.bus_action    = ACT_NONE;
        res.next_delay_ms = DELAY_NONE;
        if (!item.command) begin
            unique case (phase_reg)
                PH_RESET: begin
                    res.bus_action    = ACT_SOFT_RESET;
                    res.next_delay_ms = DELAY_RETRY;
                end
                PH_REQ_ID: begin
                    res.bus_action    = ACT_REQ_ID;
                    res.next_delay_ms = DELAY_RETRY;
                end
                PH_WAIT_ID: begin
                    if (id_match) begin
                        res.bus_action    = ACT_CONT_MODE;
                        res.next_delay_ms = DELAY_POLL;
                    end else if (timed_out) begin
                        res.next_delay_ms = DELAY_RESTART;
                    end else begin
                        res.next_delay_ms = DELAY_RETRY;
                    end
                end
                PH_POLL: begin
                    res.overflow_seen = ovf_hit;
                    res.bad_read      = !good;
                    if (good) begin
                        res.sample_valid = 1'b1;
                        res.mag_x        = $signed({item.x_high, item.x_low});
                        res.mag_y        = $signed({item.y_high, item.y_low});
                        res.mag_z        = $signed({item.z_high, item.z_low});
                    end
                    if (good || !over_limit) begin
                        res.bus_action    = ACT_REQ_DATA;
                        res.next_delay_ms = DELAY_POLL;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_RESET;
            score_reg    <= 8'd0;
            rst_time_reg <= '0;
        end else if (fire) begin
            phase_reg    <= phase_next;
            score_reg    <= score_next;
            rst_time_reg <= rst_time_next;
        end
    end
endmodule

// File: sv/mphf_out_reg.sv
// result register stage towards the receiver
module mphf_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              d_valid,
    input  mphf_pkg::result_t d_res,
    output logic              take,
    output logic              m_valid,
    input  logic              m_ready,
    output mphf_pkg::result_t m_res
);
    import mphf_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign take       = !valid_reg || m_ready;
    assign valid_next = take ? d_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && d_valid) begin
            res_reg <= d_res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;
endmodule

// File: sv/magnetometer_poll_health_fsm.sv
// top level of the magnetometer poll and health sequencer
//
// one step item enters on the s_ channel (valid/ready), one result leaves on
// the m_ channel (valid/ready) for every step; results keep the input order
// a step accepted into the input register is worked by the step logic and
// registered in the result register before it shows on the m_ channel
// throughput: one step per cycle unless the receiver stalls, set by the input
// register, single-pass step logic and result register; the sequencer state
// updates as the result register loads, so the next step sees it at once
// a reset request (command 1) is a step too and gives a result with no bus
// action and zero delay
// configuration: cfg_wr_en, cfg_index and cfg_wdata write one register per
// edge, with no wait; write only while no step is in flight
// reset (aresetn low, synchronous) empties both stages, puts the sequencer in
// the reset phase, clears the failure score and the reset time and loads the
// register defaults
// when the receiver stalls, the result is held, the input register fills and
// then s_ready drops until the next transfer on the m_ channel
module magnetometer_poll_health_fsm #(
    parameter int TIME_BITS = mphf_pkg::TIME_BITS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [mphf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mphf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_command,
    input  logic [31:0]                       s_now_ms,
    input  logic                              s_transfer_ok,
    input  logic [7:0]                        s_id_byte,
    input  logic [7:0]                        s_status_one,
    input  logic [7:0]                        s_status_two,
    input  logic [7:0]                        s_x_low,
    input  logic [7:0]                        s_x_high,
    input  logic [7:0]                        s_y_low,
    input  logic [7:0]                        s_y_high,
    input  logic [7:0]                        s_z_low,
    input  logic [7:0]                        s_z_high,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [2:0]                        m_bus_action,
    output logic [9:0]                        m_next_delay_ms,
    output logic                              m_sample_valid,
    output logic signed [15:0]                m_mag_x,
    output logic signed [15:0]                m_mag_y,
    output logic signed [15:0]                m_mag_z,
    output logic                              m_overflow_seen,
    output logic                              m_bad_read
);
    import mphf_pkg::*;

    item_t   s_item;
    item_t   q_item;
    logic    q_valid;
    logic    take;
    cfg_wr_t cfg;
    result_t step_res;
    result_t m_res;

    assign s_item.command     = s_command;
    assign s_item.now_ms      = s_now_ms;
    assign s_item.transfer_ok = s_transfer_ok;
    assign s_item.id_byte     = s_id_byte;
    assign s_item.status_one  = s_status_one;
    assign s_item.status_two  = s_status_two;
    assign s_item.x_low       = s_x_low;
    assign s_item.x_high      = s_x_high;
    assign s_item.y_low       = s_y_low;
    assign s_item.y_high      = s_y_high;
    assign s_item.z_low       = s_z_low;
    assign s_item.z_high      = s_z_high;

    assign cfg.wr_en = cfg_wr_en;
    assign cfg.index = cfg_index;
    assign cfg.wdata = cfg_wdata;

    mphf_in_reg u_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .take    (take),
        .q_valid (q_valid),
        .q_item  (q_item)
    );

    mphf_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .fire    (q_valid && take),
        .item    (q_item),
        .res     (step_res)
    );

    mphf_out_reg u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .d_valid (q_valid),
        .d_res   (step_res),
        .take    (take),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

    assign m_bus_action    = m_res.bus_action;
    assign m_next_delay_ms = m_res.next_delay_ms;
    assign m_sample_valid  = m_res.sample_valid;
    assign m_mag_x         = m_res.mag_x;
    assign m_mag_y         = m_res.mag_y;
    assign m_mag_z         = m_res.mag_z;
    assign m_overflow_seen = m_res.overflow_seen;
    assign m_bad_read      = m_res.bad_read;
endmodule

// File: sv/mphf_checker.sv
// port-level checker for the sequencer, bound to the top level
module mphf_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [2:0]         m_bus_action,
    input logic [9:0]         m_next_delay_ms,
    input logic               m_sample_valid,
    input logic signed [15:0] m_mag_x,
    input logic signed [15:0] m_mag_y,
    input logic signed [15:0] m_mag_z,
    input logic               m_overflow_seen,
    input logic               m_bad_read
);
    import mphf_pkg::*;

    // a stalled result transfer holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_bus_action)
                                && $stable(m_next_delay_ms) && $stable(m_mag_x))
        else $error("stalled result changed");

    // a good sample always asks for the next data block on the polling period
    a_sample_poll: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_sample_valid |-> m_bus_action == ACT_REQ_DATA
                                      && m_next_delay_ms == DELAY_POLL && !m_bad_read)
        else $error("good sample without data request");

    // no sample, no axis data
    a_zero_axes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_sample_valid |-> m_mag_x == 16'sd0 && m_mag_y == 16'sd0
                                       && m_mag_z == 16'sd0)
        else $error("axis data without sample");

    // a failed read either keeps polling or restarts at once
    a_bad_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_bad_read || m_overflow_seen) |->
            m_bad_read && ((m_bus_action == ACT_REQ_DATA && m_next_delay_ms == DELAY_POLL)
                        || (m_bus_action == ACT_NONE && m_next_delay_ms == DELAY_NONE)))
        else $error("failed read with wrong follow-up");
endmodule

bind magnetometer_poll_health_fsm mphf_checker u_mphf_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_bus_action    (m_bus_action),
    .m_next_delay_ms (m_next_delay_ms),
    .m_sample_valid  (m_sample_valid),
    .m_mag_x         (m_mag_x),
    .m_mag_y         (m_mag_y),
    .m_mag_z         (m_mag_z),
    .m_overflow_seen (m_overflow_seen),
    .m_bad_read      (m_bad_read)
);

// File: sim/magnetometer_poll_health_fsm_tb.sv
// self-checking testbench for the magnetometer poll and health sequencer
module magnetometer_poll_health_fsm_tb;
    import mphf_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int ITEM_W = $bits(item_t);

    typedef struct {
        item_t   step;
        bit      fixed;
        result_t res;
    } step_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    item_t                  s_step = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [2:0]             m_bus_action;
    logic [9:0]             m_next_delay_ms;
    logic                   m_sample_valid;
    logic signed [15:0]     m_mag_x;
    logic signed [15:0]     m_mag_y;
    logic signed [15:0]     m_mag_z;
    logic                   m_overflow_seen;
    logic                   m_bad_read;

    // sequencer state and register copies
    phase_t      mdl_phase = PH_RESET;
    logic [7:0]  mdl_score = '0;
    logic [31:0] mdl_reset_time = '0;
    logic [7:0]  cfg_expected_id = EXPECTED_ID_RST;
    logic [7:0]  cfg_failure_limit = FAILURE_LIMIT_RST;
    logic [15:0] cfg_reset_timeout = RESET_TIMEOUT_RST;
    logic [7:0]  cfg_ready_mask = READY_MASK_RST;
    logic [7:0]  cfg_overflow_mask = OVERFLOW_MASK_RST;

    result_t     pending_results[$];
    step_row_t   directed_rows[$];
    logic [31:0] sim_now_ms = '0;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    int          rx_hold_len = 0;
    int          errors = 0;
    int          quiet_cycles = 0;

    magnetometer_poll_health_fsm u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_step.command),
        .s_now_ms        (s_step.now_ms),
        .s_transfer_ok   (s_step.transfer_ok),
        .s_id_byte       (s_step.id_byte),
        .s_status_one    (s_step.status_one),
        .s_status_two    (s_step.status_two),
        .s_x_low         (s_step.x_low),
        .s_x_high        (s_step.x_high),
        .s_y_low         (s_step.y_low),
        .s_y_high        (s_step.y_high),
        .s_z_low         (s_step.z_low),
        .s_z_high        (s_step.z_high),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_bus_action    (m_bus_action),
        .m_next_delay_ms (m_next_delay_ms),
        .m_sample_valid  (m_sample_valid),
        .m_mag_x         (m_mag_x),
        .m_mag_y         (m_mag_y),
        .m_mag_z         (m_mag_z),
        .m_overflow_seen (m_overflow_seen),
        .m_bad_read      (m_bad_read)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic result_t predict_step(input item_t step);
        result_t     r;
        logic [31:0] elapsed;
        logic [8:0]  raised;
        logic        good;
        r = '0;
        good = 1'b0;
        if (step.command) begin
            mdl_phase = PH_RESET;
        end else begin
            case (mdl_phase)
                PH_RESET: begin
                    r.bus_action = ACT_SOFT_RESET;
                    r.next_delay_ms = DELAY_RETRY;
                    mdl_reset_time = step.now_ms;
                    mdl_score = '0;
                    mdl_phase = PH_REQ_ID;
                end
                PH_REQ_ID: begin
                    r.bus_action = ACT_REQ_ID;
                    r.next_delay_ms = DELAY_RETRY;
                    mdl_phase = PH_WAIT_ID;
                end
                PH_WAIT_ID: begin
                    elapsed = step.now_ms - mdl_reset_time;
                    if (step.id_byte == cfg_expected_id) begin
                        r.bus_action = ACT_CONT_MODE;
                        r.next_delay_ms = DELAY_POLL;
                        mdl_phase = PH_POLL;
                    end else if (elapsed > {16'h0000, cfg_reset_timeout}) begin
                        r.next_delay_ms = DELAY_RESTART;
                        mdl_phase = PH_RESET;
                    end else begin
                        r.next_delay_ms = DELAY_RETRY;
                    end
                end
                default: begin
                    if (step.transfer_ok) begin
                        if ((step.status_two & cfg_overflow_mask) != 8'h00) begin
                            r.overflow_seen = 1'b1;
                        end else if ((step.status_one & cfg_ready_mask) != 8'h00) begin
                            good = 1'b1;
                        end
                    end
                    if (good) begin
                        r.sample_valid = 1'b1;
                        r.mag_x = {step.x_high, step.x_low};
                        r.mag_y = {step.y_high, step.y_low};
                        r.mag_z = {step.z_high, step.z_low};
                        if (mdl_score != 8'h00) begin
                            mdl_score = mdl_score - 8'd1;
                        end
                        r.bus_action = ACT_REQ_DATA;
                        r.next_delay_ms = DELAY_POLL;
                    end else begin
                        r.bad_read = 1'b1;
                        raised = mdl_score + SCORE_UP;
                        mdl_score = (raised > {1'b0, SCORE_MAX}) ? SCORE_MAX : raised[7:0];
                        if (mdl_score > cfg_failure_limit) begin
                            r.next_delay_ms = DELAY_NONE;
                            mdl_phase = PH_RESET;
                        end else begin
                            r.bus_action = ACT_REQ_DATA;
                            r.next_delay_ms = DELAY_POLL;
                        end
                    end
                end
            endcase
        end
        return r;
    endfunction

    // mostly well-formed steps for the current phase, with random content
    function automatic item_t random_step(input int bad_pct, input int cmd_pct);
        item_t step;
        step = ITEM_W'({$urandom, $urandom, $urandom, $urandom});
        step.command = ($urandom_range(0, 99) < cmd_pct);
        step.now_ms = ($urandom_range(0, 19) == 0) ? $urandom : sim_now_ms;
        sim_now_ms = step.now_ms;
        case (mdl_phase)
            PH_WAIT_ID: begin
                if ($urandom_range(0, 99) < 35) begin
                    step.id_byte = cfg_expected_id;
                end
            end
            PH_POLL: begin
                if ($urandom_range(0, 99) >= bad_pct) begin
                    step.transfer_ok = 1'b1;
                    step.status_one = step.status_one | cfg_ready_mask;
                    step.status_two = step.status_two & ~cfg_overflow_mask;
                end else begin
                    case ($urandom_range(0, 2))
                        0: step.transfer_ok = 1'b0;
                        1: begin
                            step.transfer_ok = 1'b1;
                            step.status_two = step.status_two | cfg_overflow_mask;
                        end
                        default: begin
                            step.transfer_ok = 1'b1;
                            step.status_one = step.status_one & ~cfg_ready_mask;
                            step.status_two = step.status_two & ~cfg_overflow_mask;
                        end
                    endcase
                end
            end
            default: ;
        endcase
        return step;
    endfunction

    function automatic void add_row(input item_t step, input bit fixed, input result_t res);
        step_row_t r;
        r.step = step;
        r.fixed = fixed;
        r.res = res;
        directed_rows.push_back(r);
    endfunction

    task automatic send_step(input item_t step, input bit fixed, input result_t fixed_res);
        result_t predicted;
        if (tx_idle_on && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_step <= step;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predicted = predict_step(step);
        pending_results.push_back(fixed ? fixed_res : predicted);
        sim_now_ms = sim_now_ms + predicted.next_delay_ms + $urandom_range(0, 5);
    endtask

    task automatic run_random(input int count, input int bad_pct, input int cmd_pct);
        for (int i = 0; i < count; i++) begin
            send_step(random_step(bad_pct, cmd_pct), 1'b0, '0);
        end
    endtask

    task automatic settle_idle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic apply_config(input logic [7:0] eid, input logic [7:0] lim,
                                input logic [15:0] tmo, input logic [7:0] rdy,
                                input logic [7:0] ovf);
        cfg_expected_id = eid;
        cfg_failure_limit = lim;
        cfg_reset_timeout = tmo;
        cfg_ready_mask = rdy;
        cfg_overflow_mask = ovf;
        write_reg(CFG_EXPECTED_ID, {8'h00, eid});
        write_reg(CFG_FAILURE_LIMIT, {8'h00, lim});
        write_reg(CFG_RESET_TIMEOUT, tmo);
        write_reg(CFG_READY_MASK, {8'h00, rdy});
        write_reg(CFG_OVERFLOW_MASK, {8'h00, ovf});
        cfg_wr_en <= 1'b0;
    endtask

    task automatic report_mismatch(input string field, input int want, input int got_v);
        $error("%s mismatch: expected %0d, got %0d", field, want, got_v);
        errors++;
    endtask

    // receiver: random stalls, plus a long hold-off on request
    initial begin : rx_side
        int hold;
        forever begin
            if (rx_hold_len > 0) begin
                hold = rx_hold_len;
                rx_hold_len = 0;
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : check_results
        result_t got;
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_bus_action, m_next_delay_ms, m_sample_valid, m_mag_x, m_mag_y, m_mag_z,
                   m_overflow_seen, m_bad_read};
            if (pending_results.size() == 0) begin
                $error("result transfer with no step outstanding");
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.bus_action !== want.bus_action)
                    report_mismatch("bus_action", want.bus_action, got.bus_action);
                if (got.next_delay_ms !== want.next_delay_ms)
                    report_mismatch("next_delay_ms", want.next_delay_ms, got.next_delay_ms);
                if (got.sample_valid !== want.sample_valid)
                    report_mismatch("sample_valid", want.sample_valid, got.sample_valid);
                if (got.mag_x !== want.mag_x)
                    report_mismatch("mag_x", int'(want.mag_x), int'(got.mag_x));
                if (got.mag_y !== want.mag_y)
                    report_mismatch("mag_y", int'(want.mag_y), int'(got.mag_y));
                if (got.mag_z !== want.mag_z)
                    report_mismatch("mag_z", int'(want.mag_z), int'(got.mag_z));
                if (got.overflow_seen !== want.overflow_seen)
                    report_mismatch("overflow_seen", want.overflow_seen, got.overflow_seen);
                if (got.bad_read !== want.bad_read)
                    report_mismatch("bad_read", want.bad_read, got.bad_read);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
    end

    initial begin
        // reset walk, id boundary and wrap, poll read kinds, restarts
        add_row({1'b0, 32'd0, 1'b0, 8'h00, 8'h00, 8'h00, 48'h0}, 1'b1,
                {ACT_SOFT_RESET, DELAY_RETRY, 51'h0});
        add_row({1'b0, 32'd100, 1'b0, 8'h00, 8'h00, 8'h00, 48'h0}, 1'b1,
                {ACT_REQ_ID, DELAY_RETRY, 51'h0});
        add_row({1'b0, 32'd200, 1'b1, 8'h00, 8'hFF, 8'hFF, 48'hFFFF_FFFF_FFFF}, 1'b1,
                {ACT_NONE, DELAY_RETRY, 51'h0});
        add_row({1'b0, 32'd1000, 1'b0, 8'hFF, 8'h00, 8'h00, 48'h0}, 1'b1,
                {ACT_NONE, DELAY_RETRY, 51'h0});
        add_row({1'b0, 32'd1001, 1'b0, 8'h47, 8'h00, 8'h00, 48'h0}, 1'b1,
                {ACT_NONE, DELAY_RESTART, 51'h0});
        add_row({1'b0, 32'hFFFF_FFF0, 1'b0, 8'h00, 8'h00, 8'h00, 48'h0}, 1'b1,
                {ACT_SOFT_RESET, DELAY_RETRY, 51'h0});
        add_row({1'b0, 32'hFFFF_FFF8, 1'b0, 8'h00, 8'h00, 8'h00, 48'h0}, 1'b1,
                {ACT_REQ_ID, DELAY_RETRY, 51'h0});
        add_row({1'b0, 32'h0000_0010, 1'b0, 8'h47, 8'h00, 8'h00, 48'h0}, 1'b1,
                {ACT_NONE, DELAY_RETRY, 51'h0});
        add_row({1'b0, 32'h0000_0020, 1'b0, 8'h48, 8'h00, 8'h00, 48'h0}, 1'b1,
                {ACT_CONT_MODE, DELAY_POLL, 51'h0});
        add_row({1'b0, 32'h0000_0034, 1'b1, 8'h00, 8'h01, 8'h00,
                 8'hFF, 8'h7F, 8'h00, 8'h80, 8'hFF, 8'hFF}, 1'b1,
                {ACT_REQ_DATA, DELAY_POLL, 1'b1, 16'h7FFF, 16'h8000, 16'hFFFF, 1'b0, 1'b0});
        add_row({1'b0, 32'h0000_0048, 1'b0, 8'h00, 8'hFF, 8'hFF, 48'h0}, 1'b1,
                {ACT_REQ_DATA, DELAY_POLL, 1'b0, 48'h0, 1'b0, 1'b1});
        add_row({1'b0, 32'h0000_005C, 1'b1, 8'h00, 8'hFF, 8'h08, 48'h0}, 1'b1,
                {ACT_REQ_DATA, DELAY_POLL, 1'b0, 48'h0, 1'b1, 1'b1});
        add_row({1'b0, 32'h0000_0070, 1'b1, 8'h00, 8'hFE, 8'hF7, 48'hA5A5_A5A5_A5A5}, 1'b1,
                {ACT_REQ_DATA, DELAY_POLL, 1'b0, 48'h0, 1'b0, 1'b1});
        add_row({1'b0, 32'h0000_0084, 1'b1, 8'h00, 8'h81, 8'h00,
                 8'h34, 8'h12, 8'h00, 8'h00, 8'h01, 8'h80}, 1'b0, '0);
        add_row({1'b0, 32'h0000_0098, 1'b0, 8'h00, 8'h00, 8'h00, 48'h0}, 1'b0, '0);
        add_row({1'b0, 32'h0000_00AC, 1'b0, 8'h00, 8'h00, 8'h00, 48'h0}, 1'b0, '0);
        add_row({1'b0, 32'h0000_00C0, 1'b0, 8'h00, 8'h00, 8'h00, 48'h0}, 1'b1,
                {ACT_NONE, DELAY_NONE, 1'b0, 48'h0, 1'b0, 1'b1});
        add_row({1'b1, 32'hFFFF_FFFF, 1'b1, 8'hFF, 8'hFF, 8'hFF, 48'hFFFF_FFFF_FFFF}, 1'b1,
                {ACT_NONE, DELAY_NONE, 51'h0});
        add_row({1'b0, 32'd5000, 1'b0, 8'h00, 8'h00, 8'h00, 48'h0}, 1'b0, '0);
        add_row({1'b1, 32'd5050, 1'b0, 8'h00, 8'h00, 8'h00, 48'h0}, 1'b1,
                {ACT_NONE, DELAY_NONE, 51'h0});
        add_row({1'b0, 32'd5100, 1'b0, 8'h00, 8'h00, 8'h00, 48'h0}, 1'b0, '0);
        add_row({1'b0, 32'd5200, 1'b0, 8'h00, 8'h00, 8'h00, 48'h0}, 1'b0, '0);
        add_row({1'b0, 32'd5300, 1'b0, 8'h48, 8'h00, 8'h00, 48'h0}, 1'b0, '0);
        add_row({1'b0, 32'd5320, 1'b1, 8'h00, 8'h01, 8'h00,
                 8'h80, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h7F}, 1'b0, '0);
        add_row({1'b1, 32'd5340, 1'b0, 8'h00, 8'h00, 8'h00, 48'h0}, 1'b1,
                {ACT_NONE, DELAY_NONE, 51'h0});

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (directed_rows[i]) begin
            send_step(directed_rows[i].step, directed_rows[i].fixed, directed_rows[i].res);
        end
        sim_now_ms = 32'd10000;

        settle_idle();
        apply_config(EXPECTED_ID_RST, FAILURE_LIMIT_RST, RESET_TIMEOUT_RST,
                     READY_MASK_RST, OVERFLOW_MASK_RST);
        run_random(100, 30, 3);
        settle_idle();
        run_random(100, 30, 3);

        settle_idle();
        tx_idle_on = 1'b0;
        apply_config(8'h00, 8'h00, 16'h0000, 8'hFF, 8'hFF);
        run_random(150, 20, 3);

        // limit at the top so the score saturates
        settle_idle();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b0;
        apply_config(8'hFF, 8'hFF, 16'hFFFF, 8'h80, 8'h00);
        run_random(250, 90, 0);

        settle_idle();
        rx_idle_on = 1'b1;
        apply_config(8'hA5, 8'h03, 16'd150, 8'h00, 8'h01);
        run_random(100, 0, 3);

        // long receiver hold-off while steps keep coming
        settle_idle();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        apply_config(8'h48, 8'd20, 16'd500, 8'h11, 8'h88);
        rx_hold_len = 200;
        run_random(100, 25, 3);

        settle_idle();
        apply_config(8'h3C, 8'd128, 16'd2000, 8'h0F, 8'hF0);
        run_random(300, 40, 3);

        settle_idle();
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
